>>> rtl/core/vital_sign_frame_receiver_alarm_defines.svh
// assertion macros for the vital sign frame receiver
`ifndef VITAL_SIGN_FRAME_RECEIVER_ALARM_DEFINES_SVH
`define VITAL_SIGN_FRAME_RECEIVER_ALARM_DEFINES_SVH

`ifndef SYNTHESIS
`define VSFRA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define VSFRA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define VSFRA_ASSERT(lbl, prop, msg)
`define VSFRA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> rtl/core/vsfra_pkg.sv
// types, constants and helper functions of the vital sign frame receiver
package vsfra_pkg;

	localparam logic [1:0] PH_HUNT = 2'd0;
	localparam logic [1:0] PH_ADDR = 2'd1;
	localparam logic [1:0] PH_DATA = 2'd2;
	localparam logic [1:0] PH_SUM  = 2'd3;

	localparam logic [2:0] REG_SYNC      = 3'd0;
	localparam logic [2:0] REG_HEART_HIGH = 3'd1;
	localparam logic [2:0] REG_HEART_LOW  = 3'd2;
	localparam logic [2:0] REG_TEMP_HIGH  = 3'd3;
	localparam logic [2:0] REG_TEMP_LOW   = 3'd4;

	localparam logic [7:0] RST_SYNC       = 8'h37;
	localparam logic [7:0] RST_HEART_HIGH = 8'd110;
	localparam logic [7:0] RST_HEART_LOW  = 8'd60;
	localparam logic [7:0] RST_TEMP_HIGH  = 8'd38;
	localparam logic [7:0] RST_TEMP_LOW   = 8'd36;

	localparam logic [7:0] CODE_HEART = 8'h31;
	localparam logic [7:0] CODE_TEMP  = 8'h54;
	localparam logic [7:0] CODE_RIGHT = 8'h42;
	localparam logic [7:0] CODE_LEFT  = 8'h62;

	localparam logic [1:0] SENSOR_HEART = 2'd0;
	localparam logic [1:0] SENSOR_TEMP  = 2'd1;
	localparam logic [1:0] SENSOR_RIGHT = 2'd2;
	localparam logic [1:0] SENSOR_LEFT  = 2'd3;

	localparam logic [7:0] ALARM_PREAMBLE = 8'h40;
	localparam logic [7:0] ALARM_MARK     = 8'h21;
	localparam logic [5:0] ASCII_ZERO     = 6'd48;

	// position of a result within the output burst of one frame
	localparam logic [2:0] SLOT_READING = 3'd0;
	localparam logic [2:0] SLOT_MARK    = 3'd4;
	localparam logic [2:0] SLOT_ADDR    = 3'd5;
	localparam logic [2:0] SLOT_DATA    = 3'd6;
	localparam logic [2:0] SLOT_SUM     = 3'd7;

	typedef struct packed {
		logic       known;
		logic [1:0] id;
	} sensor_code_t;

	typedef struct packed {
		logic [1:0] hundreds;
		logic [3:0] tens;
		logic [3:0] ones;
	} digits_t;

	function automatic sensor_code_t sensor_lookup(input logic [7:0] code);
		sensor_code_t r;
		r.known = 1'b1;
		r.id    = SENSOR_HEART;
		case (code)
			CODE_HEART: r.id = SENSOR_HEART;
			CODE_TEMP:  r.id = SENSOR_TEMP;
			CODE_RIGHT: r.id = SENSOR_RIGHT;
			CODE_LEFT:  r.id = SENSOR_LEFT;
			default:    r.known = 1'b0;
		endcase
		return r;
	endfunction

	// decimal split of a byte: hundreds by compare, tens by reciprocal multiply
	function automatic digits_t split_digits(input logic [7:0] v);
		digits_t     d;
		logic [7:0]  rem8;
		logic [6:0]  rem;
		logic [14:0] prod;
		logic [6:0]  tens10;
		if (v >= 8'd200) begin
			d.hundreds = 2'd2;
			rem8       = v - 8'd200;
		end else if (v >= 8'd100) begin
			d.hundreds = 2'd1;
			rem8       = v - 8'd100;
		end else begin
			d.hundreds = 2'd0;
			rem8       = v;
		end
		rem    = rem8[6:0];
		prod   = 15'(rem) * 15'd205;
		d.tens = prod[14:11];
		tens10 = 7'(d.tens) * 7'd10;
		d.ones = 4'(rem - tens10);
		return d;
	endfunction

endpackage

>>> rtl/core/vital_sign_frame_receiver_alarm.sv
// Vital sign frame receiver: parses sync/address/data/checksum frames from a
// byte stream and emits a reading and, out of limits, a seven-byte alarm frame.
// One received byte is taken per cycle while in_ready is high. A byte that
// completes a valid frame loads the result register; its results follow from
// the next cycle on, one per cycle when out_ready is high: one reading, or a
// reading and seven alarm bytes if heart rate or temperature is out of limits.
// Address and data bytes of the next frame are taken while the results drain;
// the next checksum byte waits until the last result of the current frame is
// taken. Configuration writes are taken in every cycle.
`include "vital_sign_frame_receiver_alarm_defines.svh"

module vital_sign_frame_receiver_alarm (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       kind,
	output logic [1:0] sensor,
	output logic [7:0] value,
	output logic [5:0] digit_hundreds,
	output logic [5:0] digit_tens,
	output logic [5:0] digit_ones,
	output logic [7:0] tx_byte,
	output logic       last
);

	logic [7:0] sync_q, heart_high_q, heart_low_q, temp_high_q, temp_low_q;
	logic [1:0] phase_q;
	logic [7:0] addr_q, data_q;
	logic [1:0] addr_sensor_q;

	logic       pend_q, alarm_q;
	logic [2:0] idx_q;
	logic [1:0] res_sensor_q;
	logic [7:0] res_addr_q, res_data_q, res_sum_q;
	vsfra_pkg::digits_t res_digits_q;

	logic in_fire, out_fire, out_done, load;
	logic [7:0] sum;
	logic alarm_now;
	vsfra_pkg::sensor_code_t code;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q       <= vsfra_pkg::RST_SYNC;
			heart_high_q <= vsfra_pkg::RST_HEART_HIGH;
			heart_low_q  <= vsfra_pkg::RST_HEART_LOW;
			temp_high_q  <= vsfra_pkg::RST_TEMP_HIGH;
			temp_low_q   <= vsfra_pkg::RST_TEMP_LOW;
		end else if (cfg_valid) begin
			case (cfg_index)
				vsfra_pkg::REG_SYNC:       sync_q       <= cfg_data;
				vsfra_pkg::REG_HEART_HIGH: heart_high_q <= cfg_data;
				vsfra_pkg::REG_HEART_LOW:  heart_low_q  <= cfg_data;
				vsfra_pkg::REG_TEMP_HIGH:  temp_high_q  <= cfg_data;
				vsfra_pkg::REG_TEMP_LOW:   temp_low_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// input side
	assign out_fire = out_valid && out_ready;
	assign out_done = out_fire && last;
	assign in_ready = !pend_q || (phase_q != vsfra_pkg::PH_SUM) || out_done;
	assign in_fire  = in_valid && in_ready;

	assign code = vsfra_pkg::sensor_lookup(rx_byte);
	assign sum  = 8'(addr_q + data_q);
	assign load = in_fire && (phase_q == vsfra_pkg::PH_SUM) && (sum == rx_byte);

	always_comb begin
		alarm_now = 1'b0;
		case (addr_sensor_q)
			vsfra_pkg::SENSOR_HEART:
				alarm_now = (data_q > heart_high_q) || (data_q < heart_low_q);
			vsfra_pkg::SENSOR_TEMP:
				alarm_now = (data_q > temp_high_q) || (data_q < temp_low_q);
			default: alarm_now = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= vsfra_pkg::PH_HUNT;
		end else if (in_fire) begin
			case (phase_q)
				vsfra_pkg::PH_HUNT:
					if (rx_byte == sync_q) phase_q <= vsfra_pkg::PH_ADDR;
				vsfra_pkg::PH_ADDR:
					phase_q <= code.known ? vsfra_pkg::PH_DATA : vsfra_pkg::PH_HUNT;
				vsfra_pkg::PH_DATA:
					phase_q <= vsfra_pkg::PH_SUM;
				default:
					phase_q <= vsfra_pkg::PH_HUNT;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && phase_q == vsfra_pkg::PH_ADDR && code.known) begin
			addr_q        <= rx_byte;
			addr_sensor_q <= code.id;
		end
		if (in_fire && phase_q == vsfra_pkg::PH_DATA) begin
			data_q <= rx_byte;
		end
	end

	// result register and burst sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q  <= 1'b0;
			idx_q   <= vsfra_pkg::SLOT_READING;
			alarm_q <= 1'b0;
		end else if (load) begin
			pend_q  <= 1'b1;
			idx_q   <= vsfra_pkg::SLOT_READING;
			alarm_q <= alarm_now;
		end else if (out_done) begin
			pend_q <= 1'b0;
		end else if (out_fire) begin
			idx_q <= idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_sensor_q <= addr_sensor_q;
			res_addr_q   <= addr_q;
			res_data_q   <= data_q;
			res_sum_q    <= rx_byte;
			res_digits_q <= vsfra_pkg::split_digits(data_q);
		end
	end

	assign out_valid      = pend_q;
	assign kind           = (idx_q != vsfra_pkg::SLOT_READING);
	assign sensor         = res_sensor_q;
	assign value          = res_data_q;
	assign digit_hundreds = vsfra_pkg::ASCII_ZERO + 6'(res_digits_q.hundreds);
	assign digit_tens     = vsfra_pkg::ASCII_ZERO + 6'(res_digits_q.tens);
	assign digit_ones     = vsfra_pkg::ASCII_ZERO + 6'(res_digits_q.ones);
	assign last           = alarm_q ? (idx_q == vsfra_pkg::SLOT_SUM) : 1'b1;

	always_comb begin
		case (idx_q)
			vsfra_pkg::SLOT_READING: tx_byte = 8'd0;
			vsfra_pkg::SLOT_MARK:    tx_byte = vsfra_pkg::ALARM_MARK;
			vsfra_pkg::SLOT_ADDR:    tx_byte = res_addr_q;
			vsfra_pkg::SLOT_DATA:    tx_byte = res_data_q;
			vsfra_pkg::SLOT_SUM:     tx_byte = res_sum_q;
			default:                 tx_byte = vsfra_pkg::ALARM_PREAMBLE;
		endcase
	end

	`VSFRA_ASSERT(a_noalarm_single, (pend_q && !alarm_q) |-> (idx_q == vsfra_pkg::SLOT_READING), "reading without alarm must be a single result")
	`VSFRA_ASSERT(a_kind_alarm, (out_valid && kind) |-> alarm_q, "alarm byte emitted without alarm")
	`VSFRA_ASSERT_NEXT(a_burst_step, out_fire && !last, pend_q && (idx_q == $past(idx_q) + 3'd1), "burst did not advance")
	`VSFRA_ASSERT_NEXT(a_bad_addr, in_fire && (phase_q == vsfra_pkg::PH_ADDR) && !code.known, phase_q == vsfra_pkg::PH_HUNT, "unknown address did not restart hunting")

endmodule

>>> tb/sv/testbench.sv
// self-checking testbench of the vital sign frame receiver: random frames, stalls, limit settings
module testbench;

	localparam int LIMIT_CYCLES    = 200000;
	localparam int DRAIN_CYCLES    = 20;
	localparam int HOLD_CYCLES     = 300;
	localparam int ITEMS_PER_PHASE = 46;

	localparam logic KIND_READING = 1'b0;
	localparam logic KIND_ALARM   = 1'b1;

	localparam logic [2:0] REG_SPARE_FIRST = 3'd5;
	localparam logic [2:0] REG_SPARE_LAST  = 3'd7;

	typedef struct packed {
		logic       kind;
		logic [1:0] sensor;
		logic [7:0] value;
		logic [5:0] digit_hundreds;
		logic [5:0] digit_tens;
		logic [5:0] digit_ones;
		logic [7:0] tx_byte;
		logic       last;
	} frame_result_t;

	class frame_checker_t;
		logic [7:0] sync_kw;
		logic [7:0] heart_hi;
		logic [7:0] heart_lo;
		logic [7:0] temp_hi;
		logic [7:0] temp_lo;
		logic [1:0] phase;
		logic [7:0] addr_byte;
		logic [7:0] data_byte;
		logic [1:0] sensor_id;
		frame_result_t expected_results[$];
		int errors;

		function new();
			sync_kw   = vsfra_pkg::RST_SYNC;
			heart_hi  = vsfra_pkg::RST_HEART_HIGH;
			heart_lo  = vsfra_pkg::RST_HEART_LOW;
			temp_hi   = vsfra_pkg::RST_TEMP_HIGH;
			temp_lo   = vsfra_pkg::RST_TEMP_LOW;
			phase     = vsfra_pkg::PH_HUNT;
			addr_byte = 8'h00;
			data_byte = 8'h00;
			sensor_id = vsfra_pkg::SENSOR_HEART;
			errors    = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [7:0] v);
			case (idx)
				vsfra_pkg::REG_SYNC:       sync_kw  = v;
				vsfra_pkg::REG_HEART_HIGH: heart_hi = v;
				vsfra_pkg::REG_HEART_LOW:  heart_lo = v;
				vsfra_pkg::REG_TEMP_HIGH:  temp_hi  = v;
				vsfra_pkg::REG_TEMP_LOW:   temp_lo  = v;
				default: ;
			endcase
		endfunction

		function frame_result_t make_result(logic k, logic [7:0] tx, logic fin);
			frame_result_t r;
			r.kind           = k;
			r.sensor         = sensor_id;
			r.value          = data_byte;
			r.digit_hundreds = vsfra_pkg::ASCII_ZERO + 6'(data_byte / 8'd100);
			r.digit_tens     = vsfra_pkg::ASCII_ZERO + 6'((data_byte / 8'd10) % 8'd10);
			r.digit_ones     = vsfra_pkg::ASCII_ZERO + 6'(data_byte % 8'd10);
			r.tx_byte        = tx;
			r.last           = fin;
			return r;
		endfunction

		function void take_byte(logic [7:0] b);
			logic [7:0] sum;
			logic known;
			logic alarm;
			logic [6:0][7:0] alarm_frame;
			case (phase)
				vsfra_pkg::PH_HUNT: begin
					if (b == sync_kw)
						phase = vsfra_pkg::PH_ADDR;
				end
				vsfra_pkg::PH_ADDR: begin
					known = 1'b1;
					case (b)
						vsfra_pkg::CODE_HEART: sensor_id = vsfra_pkg::SENSOR_HEART;
						vsfra_pkg::CODE_TEMP:  sensor_id = vsfra_pkg::SENSOR_TEMP;
						vsfra_pkg::CODE_RIGHT: sensor_id = vsfra_pkg::SENSOR_RIGHT;
						vsfra_pkg::CODE_LEFT:  sensor_id = vsfra_pkg::SENSOR_LEFT;
						default:               known = 1'b0;
					endcase
					if (known) begin
						addr_byte = b;
						phase = vsfra_pkg::PH_DATA;
					end else begin
						phase = vsfra_pkg::PH_HUNT;
					end
				end
				vsfra_pkg::PH_DATA: begin
					data_byte = b;
					phase = vsfra_pkg::PH_SUM;
				end
				default: begin
					phase = vsfra_pkg::PH_HUNT;
					sum = addr_byte + data_byte;
					if (sum == b) begin
						case (sensor_id)
							vsfra_pkg::SENSOR_HEART:
								alarm = (data_byte > heart_hi) || (data_byte < heart_lo);
							vsfra_pkg::SENSOR_TEMP:
								alarm = (data_byte > temp_hi) || (data_byte < temp_lo);
							default:
								alarm = 1'b0;
						endcase
						expected_results.push_back(make_result(KIND_READING, 8'h00, !alarm));
						if (alarm) begin
							alarm_frame = {vsfra_pkg::ALARM_PREAMBLE,
								vsfra_pkg::ALARM_PREAMBLE, vsfra_pkg::ALARM_PREAMBLE,
								vsfra_pkg::ALARM_MARK, addr_byte, data_byte, sum};
							for (int i = 0; i < 7; i++)
								expected_results.push_back(
									make_result(KIND_ALARM, alarm_frame[6 - i], i == 6));
						end
					end
				end
			endcase
		endfunction

		function void check_field(string name, logic [7:0] want, logic [7:0] got);
			if (want !== got) begin
				errors++;
				$error("%s: expected %0d, got %0d", name, want, got);
			end
		endfunction

		function void match_result(frame_result_t got);
			frame_result_t want;
			if (expected_results.size() == 0) begin
				errors++;
				$error("result with nothing pending: kind %0d tx_byte %0d", got.kind,
					got.tx_byte);
				return;
			end
			want = expected_results.pop_front();
			check_field("kind", 8'(want.kind), 8'(got.kind));
			check_field("sensor", 8'(want.sensor), 8'(got.sensor));
			check_field("value", want.value, got.value);
			check_field("digit_hundreds", 8'(want.digit_hundreds), 8'(got.digit_hundreds));
			check_field("digit_tens", 8'(want.digit_tens), 8'(got.digit_tens));
			check_field("digit_ones", 8'(want.digit_ones), 8'(got.digit_ones));
			check_field("tx_byte", want.tx_byte, got.tx_byte);
			check_field("last", 8'(want.last), 8'(got.last));
		endfunction

		function int pending();
			return expected_results.size();
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [2:0] cfg_index;
	logic [7:0] cfg_data;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] rx_byte;
	logic       out_valid;
	logic       out_ready;
	logic       kind;
	logic [1:0] sensor;
	logic [7:0] value;
	logic [5:0] digit_hundreds;
	logic [5:0] digit_tens;
	logic [5:0] digit_ones;
	logic [7:0] tx_byte;
	logic       last;

	frame_checker_t chk;
	int cycles = 0;
	int sent = 0;
	int taken = 0;
	bit hold_req = 1'b0;

	vital_sign_frame_receiver_alarm u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.sensor(sensor),
		.value(value),
		.digit_hundreds(digit_hundreds),
		.digit_tens(digit_tens),
		.digit_ones(digit_ones),
		.tx_byte(tx_byte),
		.last(last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT_CYCLES) begin
			$display("testbench: errors");
			$finish;
		end
	end

	function automatic logic [7:0] sensor_code(int i);
		case (i)
			0:       return vsfra_pkg::CODE_HEART;
			1:       return vsfra_pkg::CODE_TEMP;
			2:       return vsfra_pkg::CODE_RIGHT;
			default: return vsfra_pkg::CODE_LEFT;
		endcase
	endfunction

	// half uniform, half close to one of the alarm limits
	function automatic logic [7:0] pick_data();
		logic [7:0] limit_val;
		if ($urandom_range(0, 1))
			return 8'($urandom);
		case ($urandom_range(0, 3))
			0:       limit_val = chk.heart_hi;
			1:       limit_val = chk.heart_lo;
			2:       limit_val = chk.temp_hi;
			default: limit_val = chk.temp_lo;
		endcase
		return limit_val + 8'($urandom_range(0, 2)) - 8'd1;
	endfunction

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = ((sent / 30) % 4 == 3) ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		rx_byte = b;
		do @(posedge clk); while (in_ready !== 1'b1);
		chk.take_byte(b);
		sent++;
		@(negedge clk);
	endtask

	task automatic send_frame(input logic [7:0] code, input logic [7:0] data, input bit spoil);
		logic [7:0] sum;
		sum = code + data;
		if (spoil)
			sum = sum ^ 8'($urandom_range(1, 255));
		send_byte(chk.sync_kw);
		send_byte(code);
		send_byte(data);
		send_byte(sum);
	endtask

	task automatic send_random_chunk();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 70) begin
			send_frame(sensor_code($urandom_range(0, 3)), pick_data(), 1'b0);
		end else if (pick < 80) begin
			send_frame(sensor_code($urandom_range(0, 3)), pick_data(), 1'b1);
		end else if (pick < 88) begin
			send_byte(chk.sync_kw);
			send_byte(8'($urandom));
		end else if (pick < 94) begin
			send_byte(chk.sync_kw);
			send_byte(sensor_code($urandom_range(0, 3)));
		end else begin
			repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
		end
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [7:0] v);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = v;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		chk.write_reg(idx, v);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic load_limits(input logic [7:0] kw, input logic [7:0] hh, input logic [7:0] hl,
		input logic [7:0] th, input logic [7:0] tl);
		write_reg(vsfra_pkg::REG_SYNC, kw);
		write_reg(vsfra_pkg::REG_HEART_HIGH, hh);
		write_reg(vsfra_pkg::REG_HEART_LOW, hl);
		write_reg(vsfra_pkg::REG_TEMP_HIGH, th);
		write_reg(vsfra_pkg::REG_TEMP_LOW, tl);
	endtask

	task automatic settle();
		in_valid = 1'b0;
		while (chk.pending() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic run_random(input bit with_hold);
		int stop;
		stop = sent + ITEMS_PER_PHASE;
		hold_req = with_hold;
		while (sent < stop) send_random_chunk();
	endtask

	// result side
	initial begin
		int gap;
		frame_result_t got;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				gap = ((taken / 40) % 3 == 2) ? 0 : $urandom_range(0, 3);
				if (gap > 0) begin
					out_ready = 1'b0;
					repeat (gap) @(negedge clk);
				end
			end
			out_ready = 1'b1;
			do @(posedge clk); while (out_valid !== 1'b1);
			got = {kind, sensor, value, digit_hundreds, digit_tens, digit_ones, tx_byte, last};
			chk.match_result(got);
			taken++;
			@(negedge clk);
		end
	end

	initial begin
		in_valid = 1'b0;
		rx_byte = 8'h00;
		cfg_valid = 1'b0;
		cfg_index = vsfra_pkg::REG_SYNC;
		cfg_data = 8'h00;
		arst_n = 1'b0;
		chk = new();
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_frame(vsfra_pkg::CODE_HEART, 8'd0, 1'b0);
		send_frame(vsfra_pkg::CODE_TEMP, 8'd255, 1'b0);
		send_frame(vsfra_pkg::CODE_RIGHT, 8'd200, 1'b0);
		send_frame(vsfra_pkg::CODE_LEFT, 8'd7, 1'b0);
		send_frame(vsfra_pkg::CODE_HEART, 8'd75, 1'b0);
		send_frame(vsfra_pkg::CODE_TEMP, 8'd37, 1'b1);
		// keyword in the address slot is dropped, not taken as a new start
		send_byte(chk.sync_kw);
		send_byte(chk.sync_kw);
		send_byte(vsfra_pkg::CODE_HEART);
		send_byte(8'h10);
		send_byte(8'h41);
		run_random(1'b1);
		settle();

		// limits wide open: no alarms
		load_limits(8'h00, 8'hff, 8'h00, 8'hff, 8'h00);
		write_reg(REG_SPARE_FIRST, 8'h5a);
		run_random(1'b0);
		settle();

		// limits crossed: every heart and temperature reading alarms
		load_limits(8'hff, 8'h00, 8'hff, 8'h00, 8'hff);
		write_reg(REG_SPARE_LAST, 8'ha5);
		run_random(1'b1);
		settle();

		repeat (2) begin
			load_limits(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
			write_reg(3'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)), 8'($urandom));
			run_random(1'b0);
			settle();
		end

		if (chk.errors == 0 && chk.pending() == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end
endmodule

>>> files.f
+incdir+rtl/core
rtl/core/vsfra_pkg.sv
rtl/core/vital_sign_frame_receiver_alarm.sv
tb/sv/testbench.sv
